[hdl/psr_pkg.sv]
// Package: shared constants, types and helpers for the point sprite rasterizer
`default_nettype none
package psr_pkg;
  localparam int COLUMNS        = 1024;
  localparam int COL_W          = $clog2(COLUMNS);
  localparam int MAX_POINT_SIZE = 8;
  localparam int SIZE_W         = 4;
  localparam int QDEPTH         = 2;
  localparam int ONE_FX         = 65536;
  localparam int HALF_FX        = 32768;

  typedef enum logic {CMD_LOAD = 1'b0, CMD_DRAW = 1'b1} cmd_t;

  typedef enum logic [2:0] {
    REG_FOCAL_LENGTH = 3'd0,
    REG_FOCAL_ASPECT = 3'd1,
    REG_HALF_WIDTH   = 3'd2,
    REG_HALF_HEIGHT  = 3'd3,
    REG_SCREEN_X_MIN = 3'd4,
    REG_SCREEN_X_MAX = 3'd5,
    REG_WINDOW_Y_MIN = 3'd6,
    REG_WINDOW_Y_MAX = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] focal_length;
    logic [31:0] focal_aspect;
    logic [31:0] half_width;
    logic [31:0] half_height;
    logic [9:0]  screen_x_min;
    logic [9:0]  screen_x_max;
    logic [9:0]  window_y_min;
    logic [9:0]  window_y_max;
  } cfg_t;

  // Draw job handed from the front to the back end
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [7:0]         color;
    logic [3:0]         size;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MULX, ST_DIVX, ST_PROJX, ST_MULY, ST_DIVY, ST_PROJY,
    ST_READ, ST_TEST, ST_EMIT
  } be_state_t;

  // Clamp a signed value into an unsigned 10-bit window
  function automatic logic [9:0] clamp10(input logic signed [17:0] v,
                                         input logic [9:0] lo,
                                         input logic [9:0] hi);
    logic [9:0] r;
    if (v < $signed({8'd0, lo}))      r = lo;
    else if (v > $signed({8'd0, hi})) r = hi;
    else                              r = v[9:0];
    return r;
  endfunction
endpackage
`default_nettype wire

[hdl/psr_if.sv]
// Interfaces: input and result channels
`default_nettype none
interface psr_in_if;
  import psr_pkg::*;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [9:0]         column;
  logic signed [31:0] column_depth;
  logic signed [15:0] column_top;
  logic signed [15:0] column_bottom;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;
  logic [7:0]         color;
  logic [3:0]         point_size;
  logic               end_of_batch;
  modport source (output valid, cmd, column, column_depth, column_top, column_bottom,
                  vertex_x, vertex_y, vertex_z, color, point_size, end_of_batch,
                  input ready);
  modport sink (input valid, cmd, column, column_depth, column_top, column_bottom,
                vertex_x, vertex_y, vertex_z, color, point_size, end_of_batch,
                output ready);
endinterface

interface psr_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] pixel_x;
  logic [9:0] pixel_y;
  logic [7:0] pixel_color;
  logic       last;
  modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface
`default_nettype wire

[hdl/psr_divider.sv]
// Iterative signed floor divider: 64-bit dividend by positive 32-bit divisor
`default_nettype none
module psr_divider
  import psr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] dividend,
  input  wire logic signed [31:0] divisor,
  output logic                    done,
  output logic signed [63:0]      quotient
);
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] d_r;
  logic        neg_r;
  logic [6:0]  cnt_r;
  logic        busy_r, done_r;
  logic [33:0] trial;
  logic [63:0] mag;
  logic [63:0] qfix;

  assign mag = dividend[63] ? (64'd0 - dividend) : dividend;

  // One restoring step per cycle
  always_comb begin
    trial   = {rem_r, q_r[63]} - {2'b00, d_r};
    if (!trial[33]) begin
      rem_nxt = trial[32:0];
      q_nxt   = {q_r[62:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[31:0], q_r[63]};
      q_nxt   = {q_r[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
        q_r    <= mag;
        rem_r  <= '0;
        d_r    <= divisor;
        neg_r  <= dividend[63];
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Floor correction for negative dividends
  always_comb begin
    if (neg_r) qfix = (rem_r != '0) ? (~q_r) : (64'd0 - q_r);
    else       qfix = q_r;
  end
  assign done     = done_r;
  assign quotient = qfix;
endmodule
`default_nettype wire

[hdl/psr_front.sv]
// Front end: accept items, write the column table, queue draw jobs
`default_nettype none
module psr_front
  import psr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  psr_in_if.sink           in_ch,
  output logic             job_valid,
  output job_t             job,
  input  wire logic        job_pop,
  input  wire logic        tbl_busy,
  output logic             tbl_we,
  output logic [COL_W-1:0] tbl_waddr,
  output logic [63:0]      tbl_wdata
);
  job_t                 q_mem [QDEPTH];
  logic [$clog2(QDEPTH):0] cnt_r;
  logic [$clog2(QDEPTH)-1:0] wp_r, rp_r;
  logic acc, push, drop;
  logic [3:0] sz;

  // Hold a load until every earlier draw has read the column table
  assign in_ch.ready = (cnt_r != QDEPTH[$clog2(QDEPTH):0]) &&
                       ((in_ch.cmd == CMD_DRAW) || ((cnt_r == '0) && !tbl_busy));
  assign acc  = in_ch.valid && in_ch.ready;
  // Drop transparent and near points at the door
  assign drop = (in_ch.color == 8'd0) || (in_ch.vertex_z <= $signed(ONE_FX));
  assign push = acc && (in_ch.cmd == CMD_DRAW) && !drop;

  always_comb begin
    if (in_ch.point_size == 4'd0)                       sz = 4'd1;
    else if (in_ch.point_size > MAX_POINT_SIZE[3:0])    sz = MAX_POINT_SIZE[3:0];
    else                                                sz = in_ch.point_size;
  end

  assign tbl_we    = acc && (in_ch.cmd == CMD_LOAD);
  assign tbl_waddr = in_ch.column[COL_W-1:0];
  assign tbl_wdata = {in_ch.column_depth, in_ch.column_top, in_ch.column_bottom};

  always_ff @(posedge clk) begin
    if (push) q_mem[wp_r] <= '{vx: in_ch.vertex_x, vy: in_ch.vertex_y,
                              vz: in_ch.vertex_z, color: in_ch.color, size: sz};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= '0;
      rp_r  <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (job_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{$clog2(QDEPTH){1'b0}}, push} - {{$clog2(QDEPTH){1'b0}}, job_pop};
    end
  end

  assign job_valid = (cnt_r != '0);
  assign job       = q_mem[rp_r];
endmodule
`default_nettype wire

[hdl/psr_back.sv]
// Back end: project, test against the column table, emit the pixel square
`default_nettype none
module psr_back
  import psr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        job_valid,
  input  wire job_t        job,
  output logic             job_pop,
  output logic             tbl_busy,
  input  wire logic        tbl_we,
  input  wire logic [COL_W-1:0] tbl_waddr,
  input  wire logic [63:0] tbl_wdata,
  psr_out_if.source        out_ch
);
  be_state_t st_r, st_nxt;
  job_t      j_r;
  logic [63:0] tbl [COLUMNS];
  logic [63:0] rd_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] qd;
  logic signed [17:0] px_r, py_r;
  logic [3:0]  ix_r, iy_r;
  logic        div_start, div_done;
  logic signed [63:0] sum;
  logic signed [47:0] rnd;
  logic signed [17:0] sat;
  logic        pass;
  logic        px_ok;
  logic signed [17:0] hf, ox, oy;
  logic        is_last;
  logic        ov_r;
  logic [9:0]  ox_r, oy_r;
  logic [7:0]  oc_r;
  logic        last_r;
  logic        emit_go;

  // Column table memory
  always_ff @(posedge clk) begin
    if (tbl_we) tbl[tbl_waddr] <= tbl_wdata;
    rd_r <= tbl[px_r[COL_W-1:0]];
  end

  psr_divider u_div (.clk, .rst_n, .start(div_start), .dividend(prod_r),
                     .divisor(j_r.vz), .done(div_done), .quotient(qd));

  // Add the screen centre offset, round half up and saturate the quotient
  always_comb begin
    sum = qd + $signed({32'd0, (st_r == ST_PROJX) ? cfg.half_width : cfg.half_height})
          + 64'sd32768;
    rnd = sum[63:16];
    if (rnd > 48'sd32767)       sat = 18'sd32767;
    else if (rnd < -48'sd32768) sat = -18'sd32768;
    else                        sat = rnd[17:0];
  end

  assign px_ok = (px_r >= $signed({8'd0, cfg.screen_x_min})) &&
                 (px_r <= $signed({8'd0, cfg.screen_x_max})) &&
                 (px_r < $signed(18'(COLUMNS))) &&
                 (py_r >= $signed({8'd0, cfg.window_y_min})) &&
                 (py_r <= $signed({8'd0, cfg.window_y_max}));
  assign pass = px_ok && (j_r.vz < $signed(rd_r[63:32])) &&
                (py_r >= $signed(rd_r[31:16])) && (py_r <= $signed(rd_r[15:0]));

  assign hf = {15'd0, j_r.size[3:1]};
  assign ox = px_r - hf + {14'd0, ix_r};
  assign oy = py_r - hf + {14'd0, iy_r};
  assign is_last = (ix_r == j_r.size - 4'd1) && (iy_r == j_r.size - 4'd1);
  assign emit_go = (st_r == ST_EMIT) && (!ov_r || out_ch.ready);

  // A job is on its way to the table read
  assign tbl_busy = (st_r != ST_IDLE) && (st_r != ST_TEST) && (st_r != ST_EMIT);

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (job_valid) st_nxt = ST_MULX;
      ST_MULX:  st_nxt = ST_DIVX;
      ST_DIVX:  if (div_done) st_nxt = ST_PROJX;
      ST_PROJX: st_nxt = ST_MULY;
      ST_MULY:  st_nxt = ST_DIVY;
      ST_DIVY:  if (div_done) st_nxt = ST_PROJY;
      ST_PROJY: st_nxt = ST_READ;
      ST_READ:  st_nxt = ST_TEST;
      ST_TEST:  st_nxt = pass ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (emit_go && is_last) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    job_pop   = (st_r == ST_IDLE) && job_valid;
    div_start = (st_r == ST_MULX) || (st_r == ST_MULY);
  end

  always_ff @(posedge clk) begin
    if (job_pop) j_r <= job;
    unique case (st_r)
      ST_PROJX: px_r <= sat;
      ST_PROJY: py_r <= sat;
      default:  ;
    endcase
    if (st_nxt == ST_MULX)      prod_r <= job.vx * $signed({32'd0, cfg.focal_length});
    else if (st_r == ST_PROJX)  prod_r <= j_r.vy * $signed({32'd0, cfg.focal_aspect});
    if (emit_go) begin
      ox_r   <= clamp10(ox, cfg.screen_x_min, cfg.screen_x_max);
      oy_r   <= clamp10(oy, cfg.window_y_min, cfg.window_y_max);
      oc_r   <= j_r.color;
      last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
      ix_r <= '0;
      iy_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (emit_go) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
      // Advance the square walk row-major
      if (st_r == ST_TEST) begin
        ix_r <= '0;
        iy_r <= '0;
      end else if (emit_go) begin
        if (ix_r == j_r.size - 4'd1) begin
          ix_r <= '0;
          iy_r <= iy_r + 4'd1;
        end else begin
          ix_r <= ix_r + 4'd1;
        end
      end
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.pixel_x     = ox_r;
  assign out_ch.pixel_y     = oy_r;
  assign out_ch.pixel_color = oc_r;
  assign out_ch.last        = last_r;
endmodule
`default_nettype wire

[hdl/point_sprite_rasterizer_core.sv]
// Top level: point sprite rasterizer with APB register port
// A draw reaches its first pixel through two 64-step divides, a table read and a test.
// The back end takes a new draw only once done with the last, held by the shared
// iterative divider and the one-pixel-per-cycle emitter, which stalls on out_ch.ready;
// a load waits while a draw is queued or has not yet read the column table.
// Reset: synchronous active-low rst_n restores the register defaults and
// empties the job queue; the column table is undefined until written.
`default_nettype none
module point_sprite_rasterizer_core
  import psr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  psr_in_if.sink           in_ch,
  psr_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  cfg_t cfg_r;
  logic job_valid, job_pop, tbl_we, tbl_busy;
  job_t job;
  logic [COL_W-1:0] tbl_waddr;
  logic [63:0] tbl_wdata;
  reg_idx_t idx;

  assign idx = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{focal_length: 32'd10485760, focal_aspect: 32'd10485760,
                 half_width: 32'd10485760, half_height: 32'd6553600,
                 screen_x_min: 10'd0, screen_x_max: 10'd319,
                 window_y_min: 10'd0, window_y_max: 10'd199};
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      unique case (idx)
        REG_FOCAL_LENGTH: cfg_r.focal_length <= cfg_pwdata;
        REG_FOCAL_ASPECT: cfg_r.focal_aspect <= cfg_pwdata;
        REG_HALF_WIDTH:   cfg_r.half_width   <= cfg_pwdata;
        REG_HALF_HEIGHT:  cfg_r.half_height  <= cfg_pwdata;
        REG_SCREEN_X_MIN: cfg_r.screen_x_min <= cfg_pwdata[9:0];
        REG_SCREEN_X_MAX: cfg_r.screen_x_max <= cfg_pwdata[9:0];
        REG_WINDOW_Y_MIN: cfg_r.window_y_min <= cfg_pwdata[9:0];
        REG_WINDOW_Y_MAX: cfg_r.window_y_max <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (idx)
      REG_FOCAL_LENGTH: cfg_prdata = cfg_r.focal_length;
      REG_FOCAL_ASPECT: cfg_prdata = cfg_r.focal_aspect;
      REG_HALF_WIDTH:   cfg_prdata = cfg_r.half_width;
      REG_HALF_HEIGHT:  cfg_prdata = cfg_r.half_height;
      REG_SCREEN_X_MIN: cfg_prdata = {22'd0, cfg_r.screen_x_min};
      REG_SCREEN_X_MAX: cfg_prdata = {22'd0, cfg_r.screen_x_max};
      REG_WINDOW_Y_MIN: cfg_prdata = {22'd0, cfg_r.window_y_min};
      REG_WINDOW_Y_MAX: cfg_prdata = {22'd0, cfg_r.window_y_max};
      default:          cfg_prdata = '0;
    endcase
  end

  psr_front u_front (.clk, .rst_n, .in_ch, .job_valid, .job, .job_pop, .tbl_busy,
                     .tbl_we, .tbl_waddr, .tbl_wdata);
  psr_back u_back (.clk, .rst_n, .cfg(cfg_r), .job_valid, .job, .job_pop, .tbl_busy,
                   .tbl_we, .tbl_waddr, .tbl_wdata, .out_ch);
endmodule
`default_nettype wire

[hdl/psr_checker.sv]
// Checker: port-level properties of the rasterizer, bound to the top level
`default_nettype none
module psr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [9:0] out_pixel_x,
  input wire logic [7:0] out_pixel_color,
  input wire logic       cfg_pready
);
  // A waiting pixel holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_x))
    else $error("stalled pixel changed");
  // Transparent color never leaves
  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pixel_color != 8'd0)
    else $error("zero color emitted");
  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");
endmodule

bind point_sprite_rasterizer_core psr_checker u_chk (
  .clk, .rst_n, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_pixel_x(out_ch.pixel_x), .out_pixel_color(out_ch.pixel_color), .cfg_pready);
`default_nettype wire

[verif/tb_point_sprite_rasterizer_core.sv]
// Testbench for the point sprite rasterizer: random and directed loads/draws, predicted pixels
`timescale 1ns / 100ps
module tb_point_sprite_rasterizer_core;
  import psr_pkg::*;

  localparam int LIMIT_CYCLES = 1_500_000;

  typedef struct {
    cmd_t               cmd;
    logic [9:0]         column;
    logic signed [31:0] col_depth;
    logic signed [15:0] col_top;
    logic signed [15:0] col_bottom;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [7:0]         color;
    logic [3:0]         size;
    logic               eob;
  } psr_item_t;

  typedef struct {
    logic [9:0] x;
    logic [9:0] y;
    logic [7:0] color;
    logic       last;
  } pixel_t;

  // Pixel predictor: register copy, column table and queue of expected pixels
  class pixel_scoreboard;
    logic [31:0] focal_len, focal_asp, half_w, half_h;
    logic [9:0]  x_lo, x_hi, y_lo, y_hi;
    int          col_depth [COLUMNS];
    int          col_top   [COLUMNS];
    int          col_bottom[COLUMNS];
    bit          written   [COLUMNS];
    pixel_t      pending[$];

    function void restore();
      focal_len = 32'd10485760; focal_asp = 32'd10485760;
      half_w    = 32'd10485760; half_h    = 32'd6553600;
      x_lo = 10'd0; x_hi = 10'd319; y_lo = 10'd0; y_hi = 10'd199;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void set_reg(reg_idx_t r, logic [31:0] v);
      case (r)
        REG_FOCAL_LENGTH: focal_len = v;
        REG_FOCAL_ASPECT: focal_asp = v;
        REG_HALF_WIDTH:   half_w = v;
        REG_HALF_HEIGHT:  half_h = v;
        REG_SCREEN_X_MIN: x_lo = v[9:0];
        REG_SCREEN_X_MAX: x_hi = v[9:0];
        REG_WINDOW_Y_MIN: y_lo = v[9:0];
        REG_WINDOW_Y_MAX: y_hi = v[9:0];
        default: ;
      endcase
    endfunction

    // Perspective divide, round half up, saturate to 16 bits
    function int project(longint c, logic [31:0] f, logic [31:0] h, longint z);
      longint p, q, r;
      p = c * longint'({32'd0, f});
      q = p / z;
      if ((p % z) != 0 && p < 0) q--;
      r = (q + longint'({32'd0, h}) + 32768) >>> 16;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return int'(r);
    endfunction

    // Column a draw would look up in the table, or -1 if it stops earlier
    function int lookup_column(psr_item_t it);
      int px;
      if (it.cmd != CMD_DRAW || it.color == 8'd0 || it.vz <= ONE_FX) return -1;
      px = project(it.vx, focal_len, half_w, it.vz);
      if (px < int'(x_lo) || px > int'(x_hi) || px >= COLUMNS) return -1;
      return px;
    endfunction

    function void note_item(psr_item_t it);
      int px, py, sz, hf, x, y;
      pixel_t p;
      if (it.cmd == CMD_LOAD) begin
        col_depth[it.column]  = it.col_depth;
        col_top[it.column]    = it.col_top;
        col_bottom[it.column] = it.col_bottom;
        written[it.column]    = 1'b1;
        return;
      end
      px = lookup_column(it);
      if (px < 0) return;
      py = project(it.vy, focal_asp, half_h, it.vz);
      if (it.vz >= col_depth[px]) return;
      if (py > int'(y_hi) || py < int'(y_lo)) return;
      if (py < col_top[px] || py > col_bottom[px]) return;
      sz = (it.size == 0) ? 1 : (it.size > MAX_POINT_SIZE) ? MAX_POINT_SIZE : it.size;
      hf = sz >> 1;
      for (int i = 0; i < sz * sz; i++) begin
        x = px - hf + i % sz;
        y = py - hf + i / sz;
        x = (x < int'(x_lo)) ? int'(x_lo) : (x > int'(x_hi)) ? int'(x_hi) : x;
        y = (y < int'(y_lo)) ? int'(y_lo) : (y > int'(y_hi)) ? int'(y_hi) : y;
        p.x = x[9:0]; p.y = y[9:0]; p.color = it.color; p.last = (i + 1 == sz * sz);
        pending.push_back(p);
      end
    endfunction

    function string check(pixel_t got);
      pixel_t e;
      if (pending.size() == 0)
        return $sformatf("unexpected pixel x=%0d y=%0d", got.x, got.y);
      e = pending.pop_front();
      if (got.x !== e.x || got.y !== e.y || got.color !== e.color || got.last !== e.last)
        return $sformatf("pixel got x=%0d y=%0d c=%0d l=%0b, want x=%0d y=%0d c=%0d l=%0b",
                         got.x, got.y, got.color, got.last, e.x, e.y, e.color, e.last);
      return "";
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  bit          calm = 1'b0;
  int          errors = 0;
  int          cycles = 0;
  pixel_scoreboard pix_sb;

  psr_in_if  in_ch();
  psr_out_if out_ch();

  point_sprite_rasterizer_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report(string msg);
    $display("mismatch @%0d: %s", cycles, msg);
    errors++;
  endtask

  // Abort on runaway
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_point_sprite_rasterizer_core: FAIL");
      $finish;
    end
  end

  // Check every pixel transfer
  always @(posedge clk) begin
    pixel_t got;
    string  msg;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.x = out_ch.pixel_x; got.y = out_ch.pixel_y;
      got.color = out_ch.pixel_color; got.last = out_ch.last;
      msg = pix_sb.check(got);
      if (msg != "") report(msg);
    end
  end

  // Stall the pixel side in bursts, none once calm
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!calm && $urandom_range(0, 1)) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {r, 2'b00}; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    pix_sb.set_reg(r, v);
    @(posedge clk);
  endtask

  // Hold valid until the transfer, then maybe idle
  task automatic transfer(psr_item_t it);
    in_ch.valid <= 1'b1; in_ch.cmd <= it.cmd; in_ch.column <= it.column;
    in_ch.column_depth <= it.col_depth; in_ch.column_top <= it.col_top;
    in_ch.column_bottom <= it.col_bottom; in_ch.vertex_x <= it.vx;
    in_ch.vertex_y <= it.vy; in_ch.vertex_z <= it.vz; in_ch.color <= it.color;
    in_ch.point_size <= it.size; in_ch.end_of_batch <= it.eob;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pix_sb.note_item(it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  function automatic psr_item_t noise_item();
    psr_item_t it;
    it.cmd = cmd_t'($urandom_range(0, 1)); it.column = 10'($urandom());
    it.col_depth = $urandom(); it.col_top = 16'($urandom());
    it.col_bottom = 16'($urandom());
    it.vx = $urandom(); it.vy = $urandom(); it.vz = $urandom();
    it.color = 8'($urandom()); it.size = 4'($urandom()); it.eob = 1'($urandom());
    return it;
  endfunction

  // Send a draw, first loading its column if the table entry is still empty
  task automatic send_draw(psr_item_t it);
    psr_item_t ld;
    int col;
    col = pix_sb.lookup_column(it);
    if (col >= 0 && !pix_sb.written[col]) begin
      ld = noise_item();
      ld.cmd = CMD_LOAD; ld.column = col[9:0];
      transfer(ld);
    end
    transfer(it);
  endtask

  // Aim a vertex at a target pixel and load a column that mostly lets it through
  task automatic aimed_draw(int tx, int ty, logic [3:0] sz, logic [7:0] c, longint z);
    psr_item_t it, ld;
    longint v;
    int px, py;
    it = noise_item();
    it.cmd = CMD_DRAW; it.vz = 32'(z); it.color = c; it.size = sz;
    if (pix_sb.focal_len != 0) begin
      v = (((longint'(tx) <<< 16) - longint'({32'd0, pix_sb.half_w})) * z)
          / longint'({32'd0, pix_sb.focal_len});
      it.vx = (v > 64'sh7FFFFFFF) ? 32'h7FFFFFFF :
              (v < -64'sh80000000) ? 32'h80000000 : 32'(v);
    end
    if (pix_sb.focal_asp != 0) begin
      v = (((longint'(ty) <<< 16) - longint'({32'd0, pix_sb.half_h})) * z)
          / longint'({32'd0, pix_sb.focal_asp});
      it.vy = (v > 64'sh7FFFFFFF) ? 32'h7FFFFFFF :
              (v < -64'sh80000000) ? 32'h80000000 : 32'(v);
    end
    px = pix_sb.lookup_column(it);
    if (px >= 0) begin
      py = pix_sb.project(it.vy, pix_sb.focal_asp, pix_sb.half_h, it.vz);
      ld = noise_item();
      ld.cmd = CMD_LOAD; ld.column = px[9:0];
      ld.col_depth = 32'(z + longint'($urandom_range(1, 32'h100000)));
      ld.col_top = 16'(py - int'($urandom_range(0, 3)));
      ld.col_bottom = 16'(py + int'($urandom_range(0, 3)));
      // occasionally occlude or shrink the column window
      case ($urandom_range(0, 9))
        0: ld.col_depth = 32'(z - longint'($urandom_range(0, 32'h8000)));
        1: ld.col_top = 16'(py + 1);
        2: ld.col_bottom = 16'(py - 1);
        default: ;
      endcase
      transfer(ld);
    end
    send_draw(it);
  endtask

  task automatic random_items(int n);
    int tx, ty;
    logic [3:0] sz;
    logic [7:0] c;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        tx = (pix_sb.x_lo <= pix_sb.x_hi) ? $urandom_range(pix_sb.x_lo, pix_sb.x_hi)
                                          : $urandom_range(0, 1023);
        ty = (pix_sb.y_lo <= pix_sb.y_hi) ? $urandom_range(pix_sb.y_lo, pix_sb.y_hi)
                                          : $urandom_range(0, 1023);
        sz = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(1, 8));
        c = ($urandom_range(0, 29) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        aimed_draw(tx, ty, sz, c, $urandom_range(32'h10001, 32'h200000));
      end else begin
        send_draw(noise_item());
      end
    end
  endtask

  // Wait until every pixel is back plus the pipeline latency
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pix_sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    psr_item_t it;
    pix_sb = new();
    pix_sb.restore();
    in_ch.valid = 1'b0; in_ch.cmd = CMD_LOAD; in_ch.column = '0; in_ch.column_depth = '0;
    in_ch.column_top = '0; in_ch.column_bottom = '0; in_ch.vertex_x = '0;
    in_ch.vertex_y = '0; in_ch.vertex_z = '0; in_ch.color = '0; in_ch.point_size = '0;
    in_ch.end_of_batch = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: table extremes, rejections, size limits, clamped corners
    it = noise_item(); it.cmd = CMD_LOAD; it.column = 10'd0;
    it.col_depth = 32'h7FFFFFFF; it.col_top = -16'sd32768; it.col_bottom = 16'sd32767;
    transfer(it);
    it.column = 10'd1023; it.col_depth = 32'h80000000; it.col_top = 16'sd32767;
    it.col_bottom = -16'sd32768;
    transfer(it);
    aimed_draw(160, 100, 4'd3, 8'd0, 32'h20000);     // transparent
    aimed_draw(160, 100, 4'd3, 8'd7, 32'h10000);     // depth exactly one
    aimed_draw(160, 100, 4'd2, 8'd9, 32'h10001);     // just past one
    aimed_draw(0, 0, 4'd8, 8'd255, 32'h40000);       // top-left clamp
    aimed_draw(319, 199, 4'd8, 8'd1, 32'h40000);     // bottom-right clamp
    aimed_draw(100, 50, 4'd0, 8'd33, 32'h30000);     // size zero
    aimed_draw(200, 150, 4'd15, 8'd44, 32'h30000);   // oversize
    aimed_draw(50, 190, 4'd1, 8'd128, 32'h7FFFFFFF);
    it = noise_item(); it.cmd = CMD_DRAW; it.vx = 32'h80000000; it.vy = 32'h7FFFFFFF;
    it.vz = 32'h20000; it.color = 8'd5; it.size = 4'd4; it.eob = 1'b1;
    send_draw(it);
    it.vz = 32'h80000000;
    send_draw(it);
    random_items(50);

    // Pause until all pixels are back, then keep going
    in_ch.valid <= 1'b0;
    while (pix_sb.pending.size() != 0) @(posedge clk);
    random_items(6);

    // Wide bounds, extreme focal and centre values
    drain();
    write_reg(REG_FOCAL_LENGTH, 32'hFFFFFFFF);
    write_reg(REG_FOCAL_ASPECT, 32'h00010000);
    write_reg(REG_HALF_WIDTH, 32'h01FF8000);
    write_reg(REG_HALF_HEIGHT, 32'h00000000);
    write_reg(REG_SCREEN_X_MIN, 32'd0);
    write_reg(REG_SCREEN_X_MAX, 32'd1023);
    write_reg(REG_WINDOW_Y_MIN, 32'd0);
    write_reg(REG_WINDOW_Y_MAX, 32'd1023);
    random_items(35);

    // Zero focal, empty column range: nothing may draw
    drain();
    write_reg(REG_FOCAL_LENGTH, 32'd0);
    write_reg(REG_FOCAL_ASPECT, 32'd0);
    write_reg(REG_HALF_WIDTH, 32'hFFFFFFFF);
    write_reg(REG_HALF_HEIGHT, 32'h00640000);
    write_reg(REG_SCREEN_X_MIN, 32'd1000);
    write_reg(REG_SCREEN_X_MAX, 32'd10);
    write_reg(REG_WINDOW_Y_MIN, 32'd5);
    write_reg(REG_WINDOW_Y_MAX, 32'd900);
    random_items(10);

    // Single-pixel screen at the far corner
    drain();
    write_reg(REG_FOCAL_LENGTH, 32'h00A00000);
    write_reg(REG_FOCAL_ASPECT, 32'h00A00000);
    write_reg(REG_HALF_WIDTH, 32'h03FF0000);
    write_reg(REG_HALF_HEIGHT, 32'h03FF0000);
    write_reg(REG_SCREEN_X_MIN, 32'd1023);
    write_reg(REG_SCREEN_X_MAX, 32'd1023);
    write_reg(REG_WINDOW_Y_MIN, 32'd1023);
    write_reg(REG_WINDOW_Y_MAX, 32'd1023);
    random_items(25);

    // Mid-range setup, no idling on either side
    drain();
    write_reg(REG_FOCAL_LENGTH, 32'h00C80000);
    write_reg(REG_FOCAL_ASPECT, 32'h00960000);
    write_reg(REG_HALF_WIDTH, 32'h01F40000);
    write_reg(REG_HALF_HEIGHT, 32'h01500000);
    write_reg(REG_SCREEN_X_MIN, 32'd100);
    write_reg(REG_SCREEN_X_MAX, 32'd900);
    write_reg(REG_WINDOW_Y_MIN, 32'd50);
    write_reg(REG_WINDOW_Y_MAX, 32'd600);
    calm = 1'b1;
    random_items(45);
    drain();

    if (errors == 0 && pix_sb.pending.size() == 0) begin
      $display("tb_point_sprite_rasterizer_core: PASS");
    end else begin
      if (pix_sb.pending.size() != 0)
        $display("%0d expected pixels never arrived", pix_sb.pending.size());
      $display("tb_point_sprite_rasterizer_core: FAIL");
    end
    $finish;
  end
endmodule

[point_sprite_rasterizer_core.f]
hdl/psr_pkg.sv
hdl/psr_if.sv
hdl/psr_divider.sv
hdl/psr_front.sv
hdl/psr_back.sv
hdl/point_sprite_rasterizer_core.sv
hdl/psr_checker.sv
verif/tb_point_sprite_rasterizer_core.sv
